// File: sv/pmpt_pkg.sv
// Package for the PS/2 mouse packet tracker.
// Holds the item, result, configuration and state types and the reset constants.
// No dependencies.
package pmpt_pkg;

	localparam int unsigned PosW   = 11;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned WheelW = 16;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 11;
	localparam int unsigned TdataOutW = 48;
	localparam int unsigned TuserOutW = 3;

	localparam logic [PosW-1:0]  MAX_X_RST   = 11'd639;
	localparam logic [PosW-1:0]  MAX_Y_RST   = 11'd479;
	localparam logic [ByteW-1:0] TIMEOUT_RST = 8'd20;

	localparam int unsigned X_SIGN_BIT = 4;
	localparam int unsigned Y_SIGN_BIT = 5;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_X   = 2'd0,
		REG_MAX_Y   = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t              operation;
		logic [ByteW-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [PosW-1:0]  max_x;
		logic [PosW-1:0]  max_y;
		logic [ByteW-1:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic [PosW-1:0]          pos_x;
		logic [PosW-1:0]          pos_y;
		logic signed [WheelW-1:0] wheel;
		logic [ByteW-1:0]         buttons;
		logic                     packet_done;
		logic                     resynced;
		logic                     four_byte_mode;
	} result_t;

	typedef struct packed {
		logic [1:0]        byte_count;
		logic [ByteW-1:0]  first_byte;
		logic [ByteW-1:0]  second_byte;
		logic [ByteW-1:0]  third_byte;
		logic              wheel_mode;
		logic [PosW-1:0]   x_position;
		logic [PosW-1:0]   y_position;
		logic [WheelW-1:0] z_total;
		logic [ByteW-1:0]  status_byte;
		logic [ByteW-1:0]  stall_ticks;
	} trk_state_t;

endpackage

// File: sv/pmpt_cfg.sv
// Configuration register bank of the PS/2 mouse packet tracker.
// Holds the clamp limits and the stall timeout; depends on pmpt_pkg.
module pmpt_cfg
	import pmpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_x         <= MAX_X_RST;
			cfg_q.max_y         <= MAX_Y_RST;
			cfg_q.timeout_limit <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_X:   cfg_q.max_x         <= cfg_data[PosW-1:0];
				REG_MAX_Y:   cfg_q.max_y         <= cfg_data[PosW-1:0];
				REG_TIMEOUT: cfg_q.timeout_limit <= cfg_data[ByteW-1:0];
				default:     ;
			endcase
		end
	end

endmodule

// File: sv/pmpt_tracker.sv
// Packet assembly, pointer tracking and resync logic of the PS/2 mouse tracker.
// Holds the tracking state and computes one result per item; depends on pmpt_pkg.
module pmpt_tracker
	import pmpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	trk_state_t st_q;
	trk_state_t st_d;

	logic              is_last;
	logic [ByteW-1:0]  y_raw;
	logic              x_neg;
	logic              y_neg;
	logic [12:0]       x_sum;
	logic [12:0]       y_diff;
	logic [PosW-1:0]   x_clamp;
	logic [PosW-1:0]   y_clamp;
	logic [3:0]        nibble;
	logic [WheelW-1:0] z_next;
	logic [ByteW-1:0]  stall_inc;
	logic              done;
	logic              flushed;

	assign is_last = ({1'b0, st_q.byte_count} >= (3'd2 + {2'b00, st_q.wheel_mode}));
	assign y_raw   = st_q.wheel_mode ? st_q.third_byte : item.data_byte;
	assign x_neg   = st_q.first_byte[X_SIGN_BIT];
	assign y_neg   = st_q.first_byte[Y_SIGN_BIT];
	assign x_sum   = {2'b00, st_q.x_position} + {{5{x_neg}}, st_q.second_byte};
	assign y_diff  = {2'b00, st_q.y_position} - {{5{y_neg}}, y_raw};

	always_comb begin
		if (x_sum[12]) begin
			x_clamp = '0;
		end else if (x_sum[11:0] > {1'b0, cfg.max_x}) begin
			x_clamp = cfg.max_x;
		end else begin
			x_clamp = x_sum[PosW-1:0];
		end
		if (y_diff[12]) begin
			y_clamp = '0;
		end else if (y_diff[11:0] > {1'b0, cfg.max_y}) begin
			y_clamp = cfg.max_y;
		end else begin
			y_clamp = y_diff[PosW-1:0];
		end
	end

	assign nibble    = item.data_byte[3:0];
	assign z_next    = st_q.wheel_mode ? (st_q.z_total + {{12{nibble[3]}}, nibble})
	                                   : st_q.z_total;
	assign stall_inc = st_q.stall_ticks + 8'd1;

	always_comb begin
		st_d    = st_q;
		done    = 1'b0;
		flushed = 1'b0;
		unique case (item.operation)
			OP_BYTE: begin
				if (is_last) begin
					done             = 1'b1;
					st_d.z_total     = z_next;
					st_d.status_byte = st_q.first_byte;
					st_d.x_position  = x_clamp;
					st_d.y_position  = y_clamp;
					st_d.stall_ticks = '0;
					st_d.byte_count  = '0;
				end else begin
					case (st_q.byte_count)
						2'd0:    st_d.first_byte  = item.data_byte;
						2'd1:    st_d.second_byte = item.data_byte;
						default: st_d.third_byte  = item.data_byte;
					endcase
					st_d.byte_count = st_q.byte_count + 2'd1;
				end
			end
			OP_TICK: begin
				if (st_q.byte_count != 2'd0) begin
					st_d.stall_ticks = stall_inc;
					if (stall_inc >= cfg.timeout_limit) begin
						flushed          = 1'b1;
						st_d.byte_count  = '0;
						st_d.stall_ticks = '0;
						st_d.wheel_mode  = ~st_q.wheel_mode;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_en) begin
			st_q <= st_d;
		end
	end

	assign result.pos_x          = st_d.x_position;
	assign result.pos_y          = st_d.y_position;
	assign result.wheel          = st_d.z_total;
	assign result.buttons        = st_d.status_byte;
	assign result.packet_done    = done;
	assign result.resynced       = flushed;
	assign result.four_byte_mode = st_d.wheel_mode;

endmodule

// File: sv/ps2_mouse_packet_tracker.sv
// The tracker takes one request per cycle: a received mouse byte or a frame tick
// enters an input register, then updates the pointer state and loads the result
// register, from which the result is offered on m_tdata and m_tuser.
// A result held by m_tready low stalls the input once the input register is full too.
// Depends on pmpt_pkg, pmpt_cfg and pmpt_tracker.
module ps2_mouse_packet_tracker
	import pmpt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ByteW-1:0]      s_tdata,  // data_byte
	input  logic                  s_tuser,  // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TdataOutW-1:0]  m_tdata,  // pos_x, pos_y, wheel, buttons, zero pad
	output logic [TuserOutW-1:0]  m_tuser,  // packet_done, resynced, four_byte_mode
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CfgIdxW-1:0]    cfg_index,
	input  logic [CfgDataW-1:0]   cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	pmpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation <= op_t'(s_tuser);
			item_s1.data_byte <= s_tdata;
		end
	end

	pmpt_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.buttons, res_q.wheel, res_q.pos_y, res_q.pos_x};
	assign m_tuser  = {res_q.four_byte_mode, res_q.resynced, res_q.packet_done};

`ifndef SYNTHESIS
	a_done_resync_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("packet completion and resync reported together");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("processed request did not reach the result register");

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while the result register could advance");

	a_resync_toggles_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_d.resynced) |=> (m_tuser[2] == !$past(u_tracker.st_q.wheel_mode)))
		else $error("resync did not toggle the packet length mode");
`endif

endmodule
